>>> src/sfcp_pkg.sv
package sfcp_pkg;

   localparam int ByteWidth  = 8;
   localparam int CsrIdxWidth = 3;

   typedef logic [ByteWidth-1:0]   byte_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;
   typedef logic [1:0]             status_type;

   // register indexes on the configuration port
   localparam csr_idx_type CSR_SYNC_FIRST   = 3'd0;
   localparam csr_idx_type CSR_SYNC_SECOND  = 3'd1;
   localparam csr_idx_type CSR_SENDER_CODE  = 3'd2;
   localparam csr_idx_type CSR_PAYLOAD_KIND = 3'd3;
   localparam csr_idx_type CSR_TAIL_CODE    = 3'd4;

   localparam byte_type RST_SYNC_FIRST   = 8'hAA;
   localparam byte_type RST_SYNC_SECOND  = 8'h55;
   localparam byte_type RST_SENDER_CODE  = 8'h01;
   localparam byte_type RST_PAYLOAD_KIND = 8'h10;
   localparam byte_type RST_TAIL_CODE    = 8'hFF;

   // frame status codes
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_BAD_ID   = 2'd1;
   localparam status_type STATUS_BAD_TAIL = 2'd2;
   localparam status_type STATUS_BAD_SUM  = 2'd3;

   typedef struct packed {
      byte_type sync_first;
      byte_type sync_second;
      byte_type sender_code;
      byte_type payload_kind;
      byte_type tail_code;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      byte_type   command;
   } result_type;

endpackage

>>> src/sfcp_csr.sv
module sfcp_csr
   import sfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  byte_type    csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // unknown indexes fall through and leave every register alone
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SYNC_FIRST:   cfg_in.sync_first   = csr_wdata;
            CSR_SYNC_SECOND:  cfg_in.sync_second  = csr_wdata;
            CSR_SENDER_CODE:  cfg_in.sender_code  = csr_wdata;
            CSR_PAYLOAD_KIND: cfg_in.payload_kind = csr_wdata;
            CSR_TAIL_CODE:    cfg_in.tail_code    = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first   <= RST_SYNC_FIRST;
         cfg_ff.sync_second  <= RST_SYNC_SECOND;
         cfg_ff.sender_code  <= RST_SENDER_CODE;
         cfg_ff.payload_kind <= RST_PAYLOAD_KIND;
         cfg_ff.tail_code    <= RST_TAIL_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> src/sfcp_parse.sv
module sfcp_parse
   import sfcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  byte_type   rx_byte,
   input  cfg_type    cfg,
   output result_type rslt
);

   typedef enum logic [2:0] {
      ST_HUNT_FIRST  = 3'b001,
      ST_HUNT_SECOND = 3'b010,
      ST_COLLECT     = 3'b100
   } state_type;

   typedef logic [2:0] pos_type;

   localparam pos_type POS_SENDER = 3'd2;
   localparam pos_type POS_KIND   = 3'd3;
   localparam pos_type POS_CMD    = 3'd4;
   localparam pos_type POS_CHECK  = 3'd5;
   localparam pos_type POS_TAIL   = 3'd6;

   state_type state_ff, state_in;
   pos_type   pos_ff, pos_in;
   byte_type  sum_ff, sum_in;
   byte_type  sender_ff, sender_in;
   byte_type  kind_ff, kind_in;
   byte_type  cmd_ff, cmd_in;
   byte_type  chk_ff, chk_in;
   status_type status;

   // judge a complete frame; the current byte is the tail
   always_comb begin
      if (sender_ff != cfg.sender_code || kind_ff != cfg.payload_kind) begin
         status = STATUS_BAD_ID;
      end else if (rx_byte != cfg.tail_code) begin
         status = STATUS_BAD_TAIL;
      end else if (sum_ff != chk_ff) begin
         status = STATUS_BAD_SUM;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      sender_in    = sender_ff;
      kind_in      = kind_ff;
      cmd_in       = cmd_ff;
      chk_in       = chk_ff;
      rslt.valid   = 1'b0;
      rslt.status  = status;
      rslt.command = (status == STATUS_OK) ? cmd_ff : '0;
      if (take) begin
         case (state_ff)
            ST_HUNT_FIRST: begin
               if (rx_byte == cfg.sync_first) begin
                  sum_in   = rx_byte;
                  state_in = ST_HUNT_SECOND;
               end
            end
            ST_HUNT_SECOND: begin
               // a mismatch restarts the hunt without rechecking this byte
               if (rx_byte == cfg.sync_second) begin
                  sum_in   = sum_ff + rx_byte;
                  pos_in   = POS_SENDER;
                  state_in = ST_COLLECT;
               end else begin
                  state_in = ST_HUNT_FIRST;
               end
            end
            ST_COLLECT: begin
               pos_in = pos_ff + 3'd1;
               case (pos_ff)
                  POS_SENDER: begin
                     sender_in = rx_byte;
                     sum_in    = sum_ff + rx_byte;
                  end
                  POS_KIND: begin
                     kind_in = rx_byte;
                     sum_in  = sum_ff + rx_byte;
                  end
                  POS_CMD: begin
                     cmd_in = rx_byte;
                     sum_in = sum_ff + rx_byte;
                  end
                  POS_CHECK: chk_in = rx_byte;
                  POS_TAIL: begin
                     rslt.valid = 1'b1;
                     state_in   = ST_HUNT_FIRST;
                  end
                  default: state_in = ST_HUNT_FIRST;
               endcase
            end
            default: state_in = ST_HUNT_FIRST;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT_FIRST;
         pos_ff   <= POS_SENDER;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      sender_ff <= sender_in;
      kind_ff   <= kind_in;
      cmd_ff    <= cmd_in;
      chk_ff    <= chk_in;
   end

endmodule

>>> src/sfcp_outq.sv
module sfcp_outq
   import sfcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type push,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output status_type rsp_frame_status,
   output byte_type   rsp_command_code
);

   logic       main_valid_ff, main_valid_in;
   status_type main_status_ff, main_status_in;
   byte_type   main_cmd_ff, main_cmd_in;
   logic       skid_valid_ff, skid_valid_in;
   status_type skid_status_ff, skid_status_in;
   byte_type   skid_cmd_ff, skid_cmd_in;
   logic       main_free;

   assign main_free        = !main_valid_ff || !rsp_stall;
   assign full             = skid_valid_ff;
   assign rsp_valid        = main_valid_ff;
   assign rsp_frame_status = main_status_ff;
   assign rsp_command_code = main_cmd_ff;

   // no push arrives while the skid entry is occupied
   always_comb begin
      main_valid_in  = main_valid_ff;
      main_status_in = main_status_ff;
      main_cmd_in    = main_cmd_ff;
      skid_valid_in  = skid_valid_ff;
      skid_status_in = skid_status_ff;
      skid_cmd_in    = skid_cmd_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in  = 1'b1;
            main_status_in = skid_status_ff;
            main_cmd_in    = skid_cmd_ff;
            skid_valid_in  = 1'b0;
         end else begin
            main_valid_in  = push.valid;
            main_status_in = push.status;
            main_cmd_in    = push.command;
         end
      end else if (push.valid) begin
         skid_valid_in  = 1'b1;
         skid_status_in = push.status;
         skid_cmd_in    = push.command;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_status_ff <= main_status_in;
      main_cmd_ff    <= main_cmd_in;
      skid_status_ff <= skid_status_in;
      skid_cmd_ff    <= skid_cmd_in;
   end

endmodule

>>> src/sync_frame_command_parser.sv
// Sync frame command parser. Received bytes arrive on the req_ channel, one
// byte per transaction, and the block takes one byte every clock cycle
// while req_stall is low. It hunts for the sync pair (sync_first, then
// sync_second), collects five more bytes into a seven-byte frame, and on
// the seventh byte issues one rsp_ transaction: frame_status (0 ok, 1 bad
// sender or payload kind, 2 bad tail, 3 bad checksum, first failing check
// wins) and command_code (frame byte four when the status is ok, zero
// otherwise). The checksum is the 8-bit sum of frame bytes zero to four
// compared against byte five. A wrong second sync byte restarts the hunt,
// and that byte is not taken as a new first sync byte. The result lands in
// the output register on the clock edge that accepts the seventh byte and
// is offered on rsp_ from the next cycle. A second result may wait in a
// skid entry; req_stall goes high only while that skid entry is occupied,
// so with rsp_stall low the block never stalls its input. The checks use
// the csr_ register values current when the seventh byte is accepted;
// writes to unknown indexes are ignored and csr_ready is always high.
module sync_frame_command_parser
   import sfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  byte_type    req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output status_type  rsp_frame_status,
   output byte_type    rsp_command_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  csr_idx_type csr_index,
   input  byte_type    csr_wdata
);

   cfg_type    cfg;
   result_type rslt;
   logic       take;
   logic       full;

   // a valid byte is taken whenever the output skid entry is free
   assign req_stall = full;
   assign take      = req_valid && !full;

   sfcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // framing state, running checksum and the judge of a complete frame
   sfcp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .rslt    (rslt)
   );

   // output register plus one skid entry
   sfcp_outq u_outq (
      .clock            (clock),
      .reset            (reset),
      .push             (rslt),
      .full             (full),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_command_code (rsp_command_code)
   );

endmodule

>>> src/sfcp_checker.sv
module sfcp_checker
   import sfcp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input status_type rsp_frame_status,
   input byte_type   rsp_command_code
);

   // reset empties the output side and frees the input
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // a rejected frame carries no command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != STATUS_OK |-> rsp_command_code == '0)
      else $error("command code set on a bad frame");

   // input stalls only when a result was held back by the consumer
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // a held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_status)
         && $stable(rsp_command_code))
      else $error("held result changed");

endmodule

bind sync_frame_command_parser sfcp_checker u_sfcp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_frame_status (rsp_frame_status),
   .rsp_command_code (rsp_command_code)
);
